### hdl/vlsm_pkg.sv
// ----------------------------------------------------------------------------
// vlsm_pkg: shared types and constants of the vlsm subnet allocator
// Holds the beat structs, status codes, sequencer states and block size math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlsm_pkg;

  localparam int MaxSubnetsDefault = 32;
  localparam int AddrWidth         = 32;
  localparam int PrefixWidth       = 6;
  localparam int HostWidth         = 31;
  localparam int SizeWidth         = 33;
  localparam int TotalWidth        = 40;
  localparam logic [PrefixWidth-1:0] PrefixMax = 6'd32;

  // configuration register indexes
  localparam logic [1:0] CfgBaseAddress = 2'd0;
  localparam logic [1:0] CfgBasePrefix  = 2'd1;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BASE    = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [HostWidth-1:0] host_count;
    logic                 last_request;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [5:0]             subnet_number;
    logic [AddrWidth-1:0]   network_address;
    logic [PrefixWidth-1:0] prefix_length;
    logic [AddrWidth-1:0]   first_host;
    logic [AddrWidth-1:0]   final_host;
    logic [AddrWidth-1:0]   broadcast_address;
    logic [AddrWidth-1:0]   usable_hosts;
    logic [HostWidth-1:0]   requested_hosts;
    logic                   last_result;
  } out_beat_t;

  // block size of a prefix, prefix assumed 32 or below
  function automatic logic [SizeWidth-1:0] block_size(input logic [PrefixWidth-1:0] p);
    return SizeWidth'(1) << (PrefixMax - p);
  endfunction

endpackage

`default_nettype wire

### hdl/vlsm_prefix_enc.sv
// ----------------------------------------------------------------------------
// vlsm_prefix_enc: host count to prefix length
// Finds the smallest prefix whose block holds the count plus two addresses; a count of zero gives 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlsm_prefix_enc (
  input  wire logic [vlsm_pkg::HostWidth-1:0]   host_count,
  output logic      [vlsm_pkg::PrefixWidth-1:0] prefix
);
  import vlsm_pkg::*;

  logic [AddrWidth-1:0]   plus_one;
  logic [PrefixWidth-1:0] bit_len;

  // bit length of count + 1 equals ceil(log2(count + 2))
  always_comb begin
    plus_one = AddrWidth'(host_count) + AddrWidth'(1);
    bit_len  = '0;
    for (int b = 0; b < AddrWidth; b++) begin
      if (plus_one[b]) bit_len = PrefixWidth'(b + 1);
    end
    if (host_count == '0) prefix = PrefixMax;
    else                  prefix = PrefixMax - bit_len;
  end

endmodule

`default_nettype wire

### hdl/vlsm_subnet_allocator.sv
// ----------------------------------------------------------------------------
// vlsm_subnet_allocator: variable length subnet allocation over one base net
// Loads host counts, then checks the set and allocates blocks prefix ascending.
// ----------------------------------------------------------------------------
// Loading: one beat a cycle, priority encode and table store in the same cycle.
// Last request: a check state, then a scan of up to 33 prefixes x N entries, each
// entry a registered table read then a compare, plus the wait for each
// result beat to be taken. Input is not ready during the scan.
// Reset (synchronous, rst_n low): clears count, total, sequencer and output valid;
// config resets to base address 0, prefix 24.
`timescale 1ns / 1ps
`default_nettype none

module vlsm_subnet_allocator #(
  parameter int MAX_SUBNETS = vlsm_pkg::MaxSubnetsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vlsm_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vlsm_pkg::out_beat_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);
  import vlsm_pkg::*;

  localparam int CW = $clog2(MAX_SUBNETS + 1);
  localparam int IW = (MAX_SUBNETS > 1) ? $clog2(MAX_SUBNETS) : 1;
  localparam int EW = PrefixWidth + HostWidth;

  // config registers
  logic [AddrWidth-1:0]   base_addr_r;
  logic [PrefixWidth-1:0] base_pfx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r <= '0;
      base_pfx_r  <= 6'd24;
    end else if (cfg_we) begin
      if (cfg_index == CfgBaseAddress) base_addr_r <= cfg_wdata;
      if (cfg_index == CfgBasePrefix)  base_pfx_r  <= cfg_wdata[PrefixWidth-1:0];
    end
  end

  // request table memory
  logic [EW-1:0] mem [MAX_SUBNETS];
  logic [EW-1:0] rd_data_r;
  logic          mem_we;
  logic [IW-1:0] rd_idx;

  // control and data registers
  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [TotalWidth-1:0]  total_r, total_nxt;
  logic [SizeWidth-1:0]   ptr_r, ptr_nxt;
  logic [SizeWidth-1:0]   bcast_r, bcast_nxt;
  logic [PrefixWidth-1:0] scan_p_r, scan_p_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          num_r, num_nxt;
  out_beat_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [PrefixWidth-1:0] enc_pfx;

  vlsm_prefix_enc u_enc (
    .host_count (in_data.host_count),
    .prefix     (enc_pfx)
  );

  assign rd_idx = idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[IW-1:0]] <= {enc_pfx, in_data.host_count};
    rd_data_r <= mem[rd_idx];
  end

  // base network math
  logic [PrefixWidth-1:0] bp;
  logic [AddrWidth-1:0]   mask, net;
  logic [SizeWidth-1:0]   cap;

  always_comb begin
    bp   = (base_pfx_r > PrefixMax) ? PrefixMax : base_pfx_r;
    mask = (bp == '0) ? '0 : ({AddrWidth{1'b1}} << (PrefixMax - bp));
    net  = base_addr_r & mask;
    cap  = block_size(bp);
  end

  // entry compare terms
  logic [PrefixWidth-1:0] ent_pfx;
  logic [HostWidth-1:0]   ent_hosts;
  logic [SizeWidth-1:0]   ent_size;
  logic [SizeWidth:0]     ent_bc;
  logic                   scan_wrap;

  assign ent_pfx   = rd_data_r[EW-1:HostWidth];
  assign ent_hosts = rd_data_r[HostWidth-1:0];
  assign ent_size  = block_size(scan_p_r);
  assign ent_bc    = {1'b0, ptr_r} + {1'b0, ent_size} - (SizeWidth+1)'(1);
  assign scan_wrap = (idx_r == count_r - CW'(1));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    ptr_nxt       = ptr_r;
    bcast_nxt     = bcast_r;
    scan_p_nxt    = scan_p_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r < CW'(MAX_SUBNETS)) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            total_nxt = total_r + TotalWidth'(block_size(enc_pfx));
          end
          if (in_data.last_request) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        out_nxt    = '0;
        scan_p_nxt = '0;
        idx_nxt    = '0;
        num_nxt    = '0;
        ptr_nxt    = SizeWidth'(net);
        bcast_nxt  = SizeWidth'(net) + cap - SizeWidth'(1);
        if (net != base_addr_r) begin
          out_nxt.status          = ST_BASE;
          out_nxt.network_address = net;
          out_nxt.last_result     = 1'b1;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_OUT;
        end else if (total_r > TotalWidth'(cap)) begin
          out_nxt.status      = ST_OVER;
          out_nxt.last_result = 1'b1;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_OUT;
        end else if (count_r == '0) begin
          total_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (ent_pfx == scan_p_r) begin
          num_nxt                 = num_r + CW'(1);
          out_nxt                 = '0;
          out_nxt.subnet_number   = 6'(num_r + CW'(1));
          out_nxt.prefix_length   = scan_p_r;
          out_nxt.requested_hosts = ent_hosts;
          out_nxt.last_result     = (num_r + CW'(1) == count_r);
          if (ent_bc > {1'b0, bcast_r} || ptr_r > bcast_r) begin
            out_nxt.status = ST_NOSPACE;
          end else begin
            out_nxt.status            = ST_ALLOC;
            out_nxt.network_address   = ptr_r[AddrWidth-1:0];
            out_nxt.broadcast_address = ent_bc[AddrWidth-1:0];
            if (ent_size > SizeWidth'(2)) begin
              out_nxt.usable_hosts = AddrWidth'(ent_size - SizeWidth'(2));
              out_nxt.first_host   = AddrWidth'(ptr_r + SizeWidth'(1));
              out_nxt.final_host   = AddrWidth'(ent_bc - (SizeWidth+1)'(1));
            end
            ptr_nxt = ptr_r + ent_size;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_READ;
          if (scan_wrap) begin
            idx_nxt    = '0;
            scan_p_nxt = scan_p_r + PrefixWidth'(1);
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_result) begin
            count_nxt = '0;
            total_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
            if (scan_wrap) begin
              idx_nxt    = '0;
              scan_p_nxt = scan_p_r + PrefixWidth'(1);
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    bcast_r  <= bcast_nxt;
    scan_p_r <= scan_p_nxt;
    idx_r    <= idx_nxt;
    num_r    <= num_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUT)) else $error("result beat outside output state");
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_result) |=> (in_ready && count_r == '0))
    else $error("run did not end after last result");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SUBNETS)) else $error("request count over table depth");

endmodule

`default_nettype wire

### sim/vlsm_subnet_allocator_tb.sv
// ----------------------------------------------------------------------------
// vlsm_subnet_allocator_tb: self-checking bench for the vlsm subnet allocator
// Loads host count sets under varied base networks, predicts every result
// beat in the bench itself, and compares the beats as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlsm_subnet_allocator_tb;
  import vlsm_pkg::*;

  localparam int Slots = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgBaseAddress;
  logic [31:0] cfg_wdata = '0;

  // bench copy of configuration and loaded set
  logic [31:0]          cur_base_addr;
  logic [5:0]           cur_base_pfx;
  logic [5:0]           held_pfx[Slots];
  logic [30:0]          held_hosts[Slots];
  int                   held_count;
  logic [63:0]          held_space;
  out_beat_t            pending_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;

  vlsm_subnet_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // smallest prefix whose block holds hosts + 2 addresses, prefix 32 for zero hosts
  function automatic logic [5:0] fit_prefix(logic [30:0] hosts);
    logic [63:0] need;
    int bits;
    if (hosts == 0) return 6'd32;
    need = 64'(hosts) + 64'd2;
    bits = 0;
    while (bits < 33 && (64'd1 << bits) < need) bits++;
    if (bits > 32) return 6'd0;
    return 6'(32 - bits);
  endfunction

  // append one predicted beat to the expected list
  function automatic void queue_row(out_beat_t row);
    pending_rows = {pending_rows, row};
  endfunction

  // load one request and, on the last one, queue the rows of the run
  function automatic void load_request(logic [30:0] hosts, logic last);
    int bp;
    int rows;
    logic [63:0] mask, net, cap, top, ptr, size, bc, usable;
    out_beat_t row;
    if (held_count < Slots) begin
      held_pfx[held_count] = fit_prefix(hosts);
      held_hosts[held_count] = hosts;
      held_space += 64'd1 << (32 - held_pfx[held_count]);
      held_count++;
    end
    if (!last) return;
    bp = (cur_base_pfx > 32) ? 32 : cur_base_pfx;
    mask = (bp == 0) ? 64'd0 : ((64'hFFFF_FFFF << (32 - bp)) & 64'hFFFF_FFFF);
    net = 64'(cur_base_addr) & mask;
    cap = 64'd1 << (32 - bp);
    top = net + cap - 64'd1;
    rows = 0;
    if (net != 64'(cur_base_addr)) begin
      row = '0;
      row.status = ST_BASE;
      row.network_address = net[31:0];
      row.last_result = 1'b1;
      queue_row(row);
    end else if (held_space > cap) begin
      row = '0;
      row.status = ST_OVER;
      row.last_result = 1'b1;
      queue_row(row);
    end else begin
      ptr = net;
      for (int p = 0; p <= 32; p++) begin
        for (int i = 0; i < held_count; i++) begin
          if (held_pfx[i] != p) continue;
          size = 64'd1 << (32 - p);
          bc = ptr + size - 64'd1;
          row = '0;
          row.subnet_number = 6'(rows + 1);
          row.prefix_length = 6'(p);
          row.requested_hosts = held_hosts[i];
          if (bc > top || ptr > top) begin
            row.status = ST_NOSPACE;
          end else begin
            usable = (size > 2) ? size - 64'd2 : 64'd0;
            row.status = ST_ALLOC;
            row.network_address = ptr[31:0];
            row.first_host = (usable != 0) ? 32'(ptr + 1) : 32'd0;
            row.final_host = (usable != 0) ? 32'(bc - 1) : 32'd0;
            row.broadcast_address = bc[31:0];
            row.usable_hosts = usable[31:0];
            ptr = (ptr + size) & 64'h1_FFFF_FFFF;
          end
          queue_row(row);
          rows++;
        end
      end
      if (rows > 0) pending_rows[pending_rows.size() - 1].last_result = 1'b1;
    end
    held_count = 0;
    held_space = '0;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    string bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = pending_rows.pop_front();
        bad = "";
        if (out_data.status != want.status) bad = {bad, " status"};
        if (out_data.subnet_number != want.subnet_number) bad = {bad, " subnet_number"};
        if (out_data.network_address != want.network_address) bad = {bad, " network"};
        if (out_data.prefix_length != want.prefix_length) bad = {bad, " prefix"};
        if (out_data.first_host != want.first_host) bad = {bad, " first_host"};
        if (out_data.final_host != want.final_host) bad = {bad, " final_host"};
        if (out_data.broadcast_address != want.broadcast_address) bad = {bad, " broadcast"};
        if (out_data.usable_hosts != want.usable_hosts) bad = {bad, " usable"};
        if (out_data.requested_hosts != want.requested_hosts) bad = {bad, " requested"};
        if (out_data.last_result != want.last_result) bad = {bad, " last_result"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch in%s\n  expected %p\n  actual   %p", bad, want, out_data);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // one request beat, called at a falling edge
  task automatic send_beat(logic [30:0] hosts, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data.host_count = hosts;
    in_data.last_request = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    load_request(hosts, last);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CfgBaseAddress) cur_base_addr = val;
    else cur_base_pfx = val[5:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // let the block drain before touching the registers
  task automatic settle();
    in_valid = 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_base(logic [31:0] addr, logic [5:0] pfx);
    settle();
    write_reg(CfgBaseAddress, addr);
    write_reg(CfgBasePrefix, {26'd0, pfx});
  endtask

  task automatic test_directed();
    // mixed sizes in a /24, ties kept in arrival order
    set_base(32'hC0A8_0000, 6'd24);
    send_beat(31'd100, 1'b0);
    send_beat(31'd50, 1'b0);
    send_beat(31'd0, 1'b0);
    send_beat(31'd1, 1'b0);
    send_beat(31'd2, 1'b0);
    send_beat(31'd2, 1'b1);
    // prefix zero, widest host count takes the whole space
    set_base(32'h0000_0000, 6'd0);
    send_beat(31'h7FFF_FFFF, 1'b1);
    // base not a network address
    set_base(32'hFFFF_FFFF, 6'd8);
    send_beat(31'd10, 1'b1);
    // total over capacity
    set_base(32'h0A00_0004, 6'd30);
    send_beat(31'd10, 1'b1);
    // base prefix above 32 acts as 32
    set_base(32'h0A00_0007, 6'd63);
    send_beat(31'd0, 1'b1);
    set_base(32'h0A00_0008, 6'd32);
    send_beat(31'd1, 1'b1);
    // table full, extra requests dropped
    set_base(32'h0A00_0000, 6'd16);
    for (int i = 0; i < Slots + 2; i++) send_beat(31'(i * 3), i == Slots + 1);
  endtask

  task automatic test_random(int items);
    int sent;
    int n, bp, p;
    logic [63:0] mask, top;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 80) begin
        // well-formed set that fits
        bp = $urandom_range(0, 29);
        mask = (bp == 0) ? 64'd0 : ((64'hFFFF_FFFF << (32 - bp)) & 64'hFFFF_FFFF);
        set_base($urandom & mask[31:0], 6'(bp));
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          p = $urandom_range(bp + 3, 32);
          top = (p >= 31) ? 64'd0 : (64'd1 << (32 - p)) - 64'd2;
          send_beat(31'($urandom_range(0, top[31:0])), i == n - 1);
        end
      end else begin
        // noise: any base, any prefix, full range counts
        set_base($urandom, 6'($urandom_range(0, 63)));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_beat(31'($urandom), i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cur_base_addr = '0;
    cur_base_pfx = 6'd24;
    held_count = 0;
    held_space = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(90);
    send_idle_pct = 70;
    test_random(90);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_random(90);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(90);
    settle();
    repeat (2200) @(negedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

### vlsm_subnet_allocator.f
hdl/vlsm_pkg.sv
hdl/vlsm_prefix_enc.sv
hdl/vlsm_subnet_allocator.sv
sim/vlsm_subnet_allocator_tb.sv
